// ----- rtl/rmq_pkg.sv -----
// shared widths, branch codes and pipeline side-band types for the dcm to quaternion core
// no dependencies

package rmq_pkg;

  // number format
  localparam int FRAC_BITS = 30;
  localparam int DW        = 32;

  // magnitude of an off-diagonal difference or sum
  localparam int MAGW = DW + 1;
  // trace of three entries
  localparam int TRW  = DW + 2;
  // radicand, unsigned once known positive, and a signed working width
  localparam int RADUW = (FRAC_BITS + 1 > DW + 2) ? FRAC_BITS + 2 : DW + 2;
  localparam int RADW  = RADUW + 2;

  // root: operand width rounded up to even, root width half of it
  localparam int SQW_RAW = RADUW + FRAC_BITS - 2;
  localparam int SQW     = SQW_RAW + (SQW_RAW % 2);
  localparam int HW      = SQW / 2;

  // root clamped to 2^32, divisor is four times that
  localparam int QW   = 33;
  localparam int HCW  = (HW > QW) ? QW : HW;
  localparam int RCW  = (HW > QW) ? HW : QW;
  localparam int DVW  = HCW + 2;

  // divider numerator and the part above the quotient bits
  localparam int NUMW = MAGW + FRAC_BITS;
  localparam int NHW  = NUMW - QW;
  localparam int CMPW = NHW + DVW;

  // signed component width before saturation
  localparam int CPW = QW + 1;

  // pipeline depths
  localparam int DIV_LAT = QW + 2;
  localparam int LAT     = HW + QW + 8;

  // largest candidate
  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  // carried alongside the root pipeline
  typedef struct packed {
    logic            invalid;
    logic [1:0]      sel;
    logic [2:0]      neg;
    logic [MAGW-1:0] mag0;
    logic [MAGW-1:0] mag1;
    logic [MAGW-1:0] mag2;
  } rmq_side_t;

  // carried alongside the dividers
  typedef struct packed {
    logic           invalid;
    logic [1:0]     sel;
    logic [2:0]     neg;
    logic [HCW-1:0] hc;
  } rmq_tail_t;

endpackage

// ----- rtl/rmq_sqrt.sv -----
// pipelined integer square root, one result bit per register stage
// depends on rmq_pkg for widths and the side-band type

module rmq_sqrt import rmq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [SQW-1:0]  in_rad,
  input  rmq_side_t       in_side,
  output logic            out_vld,
  output logic [HW-1:0]   out_root,
  output rmq_side_t       out_side
);

  logic            vld_r   [HW];
  logic [SQW-1:0]  rem_r   [HW];
  logic [HW-1:0]   root_r  [HW];
  rmq_side_t       side_r  [HW];

  logic            vld_nxt  [HW];
  logic [SQW-1:0]  rem_nxt  [HW];
  logic [HW-1:0]   root_nxt [HW];
  rmq_side_t       side_nxt [HW];

  // one trial subtraction per stage, most significant root bit first
  always_comb begin
    logic [SQW-1:0] p_rem;
    logic [SQW-1:0] trial;
    logic [HW-1:0]  p_root;
    for (int k = 0; k < HW; k++) begin
      if (k == 0) begin
        vld_nxt[k]  = in_vld;
        p_rem       = in_rad;
        p_root      = '0;
        side_nxt[k] = in_side;
      end else begin
        vld_nxt[k]  = vld_r[k-1];
        p_rem       = rem_r[k-1];
        p_root      = root_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      trial = (SQW'(p_root) << (HW - k)) | (SQW'(1) << (2 * (HW - 1 - k)));
      if (p_rem >= trial) begin
        rem_nxt[k]  = p_rem - trial;
        root_nxt[k] = p_root | (HW'(1) << (HW - 1 - k));
      end else begin
        rem_nxt[k]  = p_rem;
        root_nxt[k] = p_root;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HW; k++) vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < HW; k++) vld_r[k] <= vld_nxt[k];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    for (int k = 0; k < HW; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_vld  = vld_r[HW-1];
  assign out_root = root_r[HW-1];
  assign out_side = side_r[HW-1];

endmodule

// ----- rtl/rmq_div.sv -----
// pipelined restoring divider: (mag * 2^FRAC_BITS) / dvs, quotient clamped to 2^32
// depends on rmq_pkg for widths

module rmq_div import rmq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [MAGW-1:0] in_mag,
  input  logic [DVW-1:0]  in_dvs,
  output logic            out_vld,
  output logic [QW-1:0]   out_quo
);

  localparam logic [QW-1:0] CLAMP = QW'(1) << (QW - 1);

  logic [NUMW-1:0] num;
  logic [NHW-1:0]  num_hi;
  logic            ovf_nxt;

  logic            pre_vld_r;
  logic            pre_ovf_r;
  logic [DVW-1:0]  pre_rem_r;
  logic [QW-1:0]   pre_low_r;
  logic [DVW-1:0]  pre_dvs_r;

  logic            vld_r [QW];
  logic            ovf_r [QW];
  logic [DVW-1:0]  rem_r [QW];
  logic [QW-1:0]   low_r [QW];
  logic [QW-1:0]   quo_r [QW];
  logic [DVW-1:0]  dvs_r [QW];

  logic            vld_nxt [QW];
  logic            ovf_nxt_a [QW];
  logic [DVW-1:0]  rem_nxt [QW];
  logic [QW-1:0]   low_nxt [QW];
  logic [QW-1:0]   quo_nxt [QW];
  logic [DVW-1:0]  dvs_nxt [QW];

  logic            out_vld_r;
  logic [QW-1:0]   out_quo_r;

  // bits above the quotient range decide overflow up front
  assign num     = {in_mag, {FRAC_BITS{1'b0}}};
  assign num_hi  = num[NUMW-1:QW];
  assign ovf_nxt = CMPW'(num_hi) >= CMPW'(in_dvs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_ovf_r <= ovf_nxt;
    pre_rem_r <= ovf_nxt ? '0 : DVW'(num_hi);
    pre_low_r <= num[QW-1:0];
    pre_dvs_r <= in_dvs;
  end

  // one quotient bit per stage
  always_comb begin
    logic [DVW:0]    rem2;
    logic [DVW-1:0]  p_rem;
    logic [QW-1:0]   p_low;
    logic [QW-1:0]   p_quo;
    logic [DVW-1:0]  p_dvs;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        vld_nxt[j]   = pre_vld_r;
        ovf_nxt_a[j] = pre_ovf_r;
        p_rem        = pre_rem_r;
        p_low        = pre_low_r;
        p_quo        = '0;
        p_dvs        = pre_dvs_r;
      end else begin
        vld_nxt[j]   = vld_r[j-1];
        ovf_nxt_a[j] = ovf_r[j-1];
        p_rem        = rem_r[j-1];
        p_low        = low_r[j-1];
        p_quo        = quo_r[j-1];
        p_dvs        = dvs_r[j-1];
      end
      rem2       = {p_rem, p_low[QW-1]};
      dvs_nxt[j] = p_dvs;
      low_nxt[j] = p_low << 1;
      if (rem2 >= {1'b0, p_dvs}) begin
        rem_nxt[j] = DVW'(rem2 - {1'b0, p_dvs});
        quo_nxt[j] = {p_quo[QW-2:0], 1'b1};
      end else begin
        rem_nxt[j] = rem2[DVW-1:0];
        quo_nxt[j] = {p_quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QW; j++) vld_r[j] <= 1'b0;
    end else begin
      for (int j = 0; j < QW; j++) vld_r[j] <= vld_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      ovf_r[j] <= ovf_nxt_a[j];
      rem_r[j] <= rem_nxt[j];
      low_r[j] <= low_nxt[j];
      quo_r[j] <= quo_nxt[j];
      dvs_r[j] <= dvs_nxt[j];
    end
  end

  // clamp to 2^32
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_r[QW-1] || (quo_r[QW-1][QW-1] && (|quo_r[QW-1][QW-2:0]))) begin
      out_quo_r <= CLAMP;
    end else begin
      out_quo_r <= quo_r[QW-1];
    end
  end

  assign out_vld = out_vld_r;
  assign out_quo = out_quo_r;

endmodule

// ----- rtl/rotation_matrix_to_quaternion_core.sv -----
// direction-cosine matrix to quaternion, branch chosen on the largest of the trace and the diagonal terms
// throughput: one matrix per cycle, every stage registered; busy stays low, never stalls
// latency set by a root stage per result bit and a divider stage per quotient bit
// reset (synchronous, rst_n low) clears all valid bits; data registers are not reset
// depends on rmq_pkg, rmq_sqrt, rmq_div

module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] in_m00,
  input  logic signed [DW-1:0] in_m01,
  input  logic signed [DW-1:0] in_m02,
  input  logic signed [DW-1:0] in_m10,
  input  logic signed [DW-1:0] in_m11,
  input  logic signed [DW-1:0] in_m12,
  input  logic signed [DW-1:0] in_m20,
  input  logic signed [DW-1:0] in_m21,
  input  logic signed [DW-1:0] in_m22,
  output logic                 out_strobe,
  output logic signed [DW-1:0] out_quat_w,
  output logic signed [DW-1:0] out_quat_x,
  output logic signed [DW-1:0] out_quat_y,
  output logic signed [DW-1:0] out_quat_z,
  output logic                 out_invalid
);

  localparam logic signed [RADW-1:0] ONE_RAD = RADW'(1) <<< FRAC_BITS;
  localparam logic signed [CPW-1:0]  SAT_MAX = CPW'(2147483647);
  localparam logic signed [CPW-1:0]  SAT_MIN = -(CPW'(1) <<< (DW - 1));

  // stage 1: capture
  logic                 v1_r;
  logic signed [DW-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  // stage 2: trace, differences and sums
  logic                   v2_r;
  logic signed [TRW-1:0]  tr_r, d0_r, d1_r, d2_r;
  logic signed [MAGW-1:0] dx_r, dy_r, dz_r, sxy_r, sxz_r, syz_r;

  // stage 3: branch, radicand, numerators
  logic                   v3_r;
  logic [RADUW-1:0]       rad_r;
  rmq_side_t              side3_r;
  logic signed [TRW-1:0]  big_nxt;
  logic [1:0]             sel_nxt;
  logic signed [RADW-1:0] rad_nxt;
  logic signed [MAGW-1:0] n0_nxt, n1_nxt, n2_nxt;
  rmq_side_t              side3_nxt;

  // root pipeline outputs
  logic                   sq_vld;
  logic [HW-1:0]          sq_root;
  rmq_side_t              sq_side;

  // stage 4: clamp root, hand to dividers
  logic                   v4_r;
  rmq_tail_t              tail4_r;
  logic [MAGW-1:0]        mag0_r, mag1_r, mag2_r;
  logic [HCW-1:0]         hc_nxt;

  // side-band delay across the dividers
  rmq_tail_t              tail_r [DIV_LAT];

  logic                   dv_vld;
  logic                   dv_vld1;
  logic                   dv_vld2;
  logic [QW-1:0]          q0, q1, q2;

  // stage 5: assemble signed components
  logic                   v5_r;
  logic                   inv5_r;
  logic signed [CPW-1:0]  w5_r, x5_r, y5_r, z5_r;
  logic signed [CPW-1:0]  s0_nxt, s1_nxt, s2_nxt, hs_nxt;
  logic signed [CPW-1:0]  w5_nxt, x5_nxt, y5_nxt, z5_nxt;
  rmq_tail_t              tail_out;

  // stage 6: sign fix-up and saturation
  logic                   out_strobe_r;
  logic                   out_invalid_r;
  logic signed [DW-1:0]   qw_r, qx_r, qy_r, qz_r;
  logic                   flip;

  function automatic logic signed [DW-1:0] sat(input logic signed [CPW-1:0] v);
    logic signed [CPW-1:0] t;
    t = v;
    if (t > SAT_MAX) t = SAT_MAX;
    if (t < SAT_MIN) t = SAT_MIN;
    return t[DW-1:0];
  endfunction

  // no back-pressure anywhere in the pipeline
  assign busy = 1'b0;

  // valid chain for the stages held in this module
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= start && !busy;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= sq_vld;
      v5_r         <= dv_vld && dv_vld1 && dv_vld2;
      out_strobe_r <= v5_r;
    end
  end

  // input transfer
  always_ff @(posedge clk) begin
    m00_r <= in_m00;
    m01_r <= in_m01;
    m02_r <= in_m02;
    m10_r <= in_m10;
    m11_r <= in_m11;
    m12_r <= in_m12;
    m20_r <= in_m20;
    m21_r <= in_m21;
    m22_r <= in_m22;
  end

  // trace and off-diagonal terms
  always_ff @(posedge clk) begin
    tr_r  <= TRW'(m00_r) + TRW'(m11_r) + TRW'(m22_r);
    d0_r  <= TRW'(m00_r);
    d1_r  <= TRW'(m11_r);
    d2_r  <= TRW'(m22_r);
    dx_r  <= MAGW'(m12_r) - MAGW'(m21_r);
    dy_r  <= MAGW'(m20_r) - MAGW'(m02_r);
    dz_r  <= MAGW'(m01_r) - MAGW'(m10_r);
    sxy_r <= MAGW'(m01_r) + MAGW'(m10_r);
    sxz_r <= MAGW'(m02_r) + MAGW'(m20_r);
    syz_r <= MAGW'(m12_r) + MAGW'(m21_r);
  end

  // largest candidate, earlier wins on a tie; radicand; numerators per branch
  always_comb begin
    big_nxt = tr_r;
    sel_nxt = SEL_TRACE;
    if (d0_r > big_nxt) begin
      big_nxt = d0_r;
      sel_nxt = SEL_X;
    end
    if (d1_r > big_nxt) begin
      big_nxt = d1_r;
      sel_nxt = SEL_Y;
    end
    if (d2_r > big_nxt) begin
      big_nxt = d2_r;
      sel_nxt = SEL_Z;
    end
    rad_nxt = ONE_RAD + (RADW'(big_nxt) <<< 1) - RADW'(tr_r);
    case (sel_nxt)
      SEL_TRACE: begin
        n0_nxt = dx_r;  n1_nxt = dy_r;  n2_nxt = dz_r;
      end
      SEL_X: begin
        n0_nxt = dx_r;  n1_nxt = sxy_r; n2_nxt = sxz_r;
      end
      SEL_Y: begin
        n0_nxt = dy_r;  n1_nxt = sxy_r; n2_nxt = syz_r;
      end
      default: begin
        n0_nxt = dz_r;  n1_nxt = sxz_r; n2_nxt = syz_r;
      end
    endcase
    side3_nxt.invalid = (rad_nxt <= 0);
    side3_nxt.sel     = sel_nxt;
    side3_nxt.neg     = {n2_nxt[MAGW-1], n1_nxt[MAGW-1], n0_nxt[MAGW-1]};
    side3_nxt.mag0    = n0_nxt[MAGW-1] ? MAGW'(-n0_nxt) : MAGW'(n0_nxt);
    side3_nxt.mag1    = n1_nxt[MAGW-1] ? MAGW'(-n1_nxt) : MAGW'(n1_nxt);
    side3_nxt.mag2    = n2_nxt[MAGW-1] ? MAGW'(-n2_nxt) : MAGW'(n2_nxt);
  end

  always_ff @(posedge clk) begin
    rad_r   <= rad_nxt[RADUW-1:0];
    side3_r <= side3_nxt;
  end

  // root of radicand * 2^(FRAC_BITS-2)
  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_rad   (SQW'(rad_r) << (FRAC_BITS - 2)),
    .in_side  (side3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // clamp the root to 2^32
  assign hc_nxt = (RCW'(sq_root) > (RCW'(1) << (QW - 1))) ? HCW'(RCW'(1) << (QW - 1))
                                                          : HCW'(sq_root);

  always_ff @(posedge clk) begin
    tail4_r.invalid <= sq_side.invalid;
    tail4_r.sel     <= sq_side.sel;
    tail4_r.neg     <= sq_side.neg;
    tail4_r.hc      <= hc_nxt;
    mag0_r          <= sq_side.mag0;
    mag1_r          <= sq_side.mag1;
    mag2_r          <= sq_side.mag2;
  end

  // three dividers share the divisor 4*h
  rmq_div u_div0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v4_r),
    .in_mag  (mag0_r),
    .in_dvs  ({tail4_r.hc, 2'b00}),
    .out_vld (dv_vld),
    .out_quo (q0)
  );

  rmq_div u_div1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v4_r),
    .in_mag  (mag1_r),
    .in_dvs  ({tail4_r.hc, 2'b00}),
    .out_vld (dv_vld1),
    .out_quo (q1)
  );

  rmq_div u_div2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v4_r),
    .in_mag  (mag2_r),
    .in_dvs  ({tail4_r.hc, 2'b00}),
    .out_vld (dv_vld2),
    .out_quo (q2)
  );

  // side-band delay matching the divider depth
  always_ff @(posedge clk) begin
    tail_r[0] <= tail4_r;
    for (int i = 1; i < DIV_LAT; i++) tail_r[i] <= tail_r[i-1];
  end

  assign tail_out = tail_r[DIV_LAT-1];

  // signed quotients and component placement
  always_comb begin
    s0_nxt = tail_out.neg[0] ? -CPW'(q0) : CPW'(q0);
    s1_nxt = tail_out.neg[1] ? -CPW'(q1) : CPW'(q1);
    s2_nxt = tail_out.neg[2] ? -CPW'(q2) : CPW'(q2);
    hs_nxt = CPW'(tail_out.hc);
    case (tail_out.sel)
      SEL_TRACE: begin
        w5_nxt = hs_nxt; x5_nxt = s0_nxt; y5_nxt = s1_nxt; z5_nxt = s2_nxt;
      end
      SEL_X: begin
        w5_nxt = s0_nxt; x5_nxt = hs_nxt; y5_nxt = s1_nxt; z5_nxt = s2_nxt;
      end
      SEL_Y: begin
        w5_nxt = s0_nxt; x5_nxt = s1_nxt; y5_nxt = hs_nxt; z5_nxt = s2_nxt;
      end
      default: begin
        w5_nxt = s0_nxt; x5_nxt = s1_nxt; y5_nxt = s2_nxt; z5_nxt = hs_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    inv5_r <= tail_out.invalid;
    w5_r   <= w5_nxt;
    x5_r   <= x5_nxt;
    y5_r   <= y5_nxt;
    z5_r   <= z5_nxt;
  end

  // negate all when w is below zero, saturate, zero on invalid
  assign flip = w5_r[CPW-1];

  always_ff @(posedge clk) begin
    out_invalid_r <= inv5_r;
    if (inv5_r) begin
      qw_r <= '0;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else begin
      qw_r <= sat(flip ? -w5_r : w5_r);
      qx_r <= sat(flip ? -x5_r : x5_r);
      qy_r <= sat(flip ? -y5_r : y5_r);
      qz_r <= sat(flip ? -z5_r : z5_r);
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_invalid = out_invalid_r;
  assign out_quat_w  = qw_r;
  assign out_quat_x  = qx_r;
  assign out_quat_y  = qy_r;
  assign out_quat_z  = qz_r;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_invalid |->
      out_quat_w == '0 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0)
    else $error("invalid result carries non-zero components");

  a_scalar_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_invalid |-> !out_quat_w[DW-1])
    else $error("valid result has negative scalar part");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without a transfer in at the pipeline depth");
`endif

endmodule
